[sv/sosc_pkg.sv]
// Package for the sum-of-squares conversion pipeline.
// Field widths, derived datapath widths, kind and path codes, iteration stage record.
// No dependencies.
`default_nettype none

package sosc_pkg;

    // width of the supply and amount fields on the ports
    localparam int FIELD_W     = 63;
    // working width of supplies and amounts (range 16..63)
    localparam int AMT_W       = 63;
    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

    // this + amount needs one extra bit; the square root is of the same width
    localparam int ROOT_W      = AMT_W + 1;
    localparam int HALF_W      = (ROOT_W + 1) / 2;
    localparam int HIGH_W      = ROOT_W - HALF_W;
    localparam int PROD_W      = 2 * ROOT_W;
    localparam int SREM_W      = ROOT_W + 2;

    localparam int IN_TDATA_W  = ((3 * FIELD_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam logic [1:0] KIND_OUT  = 2'd0;
    localparam logic [1:0] KIND_IN   = 2'd1;
    localparam logic [1:0] KIND_RATE = 2'd2;

    typedef enum logic [1:0] {
        MODE_OUT,
        MODE_IN,
        MODE_RATE,
        MODE_NONE
    } mode_t;

    // one square-root / divide iteration stage
    typedef struct packed {
        mode_t              mode;
        logic               rej;
        logic               ovf;
        logic               up;
        logic [AMT_W-1:0]   other;
        logic [PROD_W-1:0]  x;
        logic [SREM_W-1:0]  srem;
        logic [ROOT_W-1:0]  root;
        logic [AMT_W-1:0]   nlo;
        logic [AMT_W-1:0]   drem;
        logic [AMT_W-1:0]   quo;
    } iter_t;

endpackage

`default_nettype wire

[sv/sum_of_squares_conversion.sv]
// Sum-of-squares conversion: pipelined squares, square root and divider.
// Depends on sosc_pkg.
//
//  channel   dir  handshake           payload
//  s_        in   s_tvalid/s_tready   tdata: cash, bond, amount; tuser: kind, pool, round_up
//  m_        out  m_tvalid/m_tready   tdata: result_amount; tuser: rejected, saturated
//
// One item per cycle while m_ is not stalled; the pipeline depth is set by the
// one-bit-per-stage square root, with the divider running in the same stages.
// Reset clears the valid bits only. A stall on m_ holds every stage, and s_tready
// follows m_tready whenever the output register is full.
`default_nettype none

module sum_of_squares_conversion
    import sosc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    // [62:0] supply_cash, [125:63] supply_bond, [188:126] amount, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] kind, [2] pool_select, [3] round_up
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    // [62:0] result_amount, zero pad
    output      logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] rejected, [1] saturated
    output      logic [OUT_TUSER_W-1:0] m_tuser
);

    logic adv;

    // ---------------- stage 1: select pools, pick path
    logic [AMT_W-1:0] in_cash, in_bond, in_d, in_this, in_other;
    mode_t            in_mode;

    logic             p1_valid_reg;
    mode_t            p1_mode_reg;
    logic [AMT_W-1:0] p1_this_reg, p1_other_reg, p1_d_reg;
    logic             p1_up_reg;

    assign in_cash  = s_tdata[AMT_W-1:0];
    assign in_bond  = s_tdata[FIELD_W+AMT_W-1:FIELD_W];
    assign in_d     = s_tdata[2*FIELD_W+AMT_W-1:2*FIELD_W];
    assign in_this  = s_tuser[2] ? in_bond : in_cash;
    assign in_other = s_tuser[2] ? in_cash : in_bond;

    always_comb
    begin
        case (s_tuser[1:0])
            KIND_OUT:  in_mode = MODE_OUT;
            KIND_IN:   in_mode = MODE_IN;
            KIND_RATE:
            begin
                if (in_other == '0)
                    in_mode = MODE_OUT;
                else if (in_this == '0)
                    in_mode = MODE_IN;
                else
                    in_mode = MODE_RATE;
            end
            default:   in_mode = MODE_NONE;
        endcase
    end

    // ---------------- stage 2: shifted supply and range check
    logic             p2_valid_reg;
    mode_t            p2_mode_reg;
    logic [AMT_W-1:0] p2_this_reg, p2_other_reg, p2_d_reg;
    logic             p2_up_reg, p2_rej_reg;
    logic [ROOT_W-1:0] p2_t_reg, p2_t_next;

    always_comb
    begin
        if (p1_mode_reg == MODE_OUT)
            p2_t_next = {1'b0, p1_this_reg} - {1'b0, p1_d_reg};
        else
            p2_t_next = {1'b0, p1_this_reg} + {1'b0, p1_d_reg};
    end

    // ---------------- stage 3: partial products
    logic [ROOT_W-1:0] w_this, w_other, w_d;
    logic              p3_valid_reg;
    mode_t             p3_mode_reg;
    logic [AMT_W-1:0]  p3_other_reg;
    logic              p3_up_reg, p3_rej_reg;
    logic [2*HIGH_W-1:0]        p3_a_hh_reg, p3_b_hh_reg, p3_t_hh_reg, p3_n_hh_reg;
    logic [HIGH_W+HALF_W-1:0]   p3_a_hl_reg, p3_b_hl_reg, p3_t_hl_reg;
    logic [HIGH_W+HALF_W-1:0]   p3_n_hl_reg, p3_n_lh_reg;
    logic [2*HALF_W-1:0]        p3_a_ll_reg, p3_b_ll_reg, p3_t_ll_reg, p3_n_ll_reg;

    assign w_this  = {1'b0, p2_this_reg};
    assign w_other = {1'b0, p2_other_reg};
    assign w_d     = {1'b0, p2_d_reg};

    // ---------------- stage 4: full products
    logic              p4_valid_reg;
    mode_t             p4_mode_reg;
    logic [AMT_W-1:0]  p4_other_reg;
    logic              p4_up_reg, p4_rej_reg;
    logic [PROD_W-1:0] p4_sqa_reg, p4_sqb_reg, p4_sqt_reg, p4_num_reg;
    logic [PROD_W-1:0] p4_sqa_next, p4_sqb_next, p4_sqt_next, p4_num_next;

    assign p4_sqa_next = (PROD_W'(p3_a_hh_reg) << (2 * HALF_W))
                       + (PROD_W'(p3_a_hl_reg) << (HALF_W + 1)) + PROD_W'(p3_a_ll_reg);
    assign p4_sqb_next = (PROD_W'(p3_b_hh_reg) << (2 * HALF_W))
                       + (PROD_W'(p3_b_hl_reg) << (HALF_W + 1)) + PROD_W'(p3_b_ll_reg);
    assign p4_sqt_next = (PROD_W'(p3_t_hh_reg) << (2 * HALF_W))
                       + (PROD_W'(p3_t_hl_reg) << (HALF_W + 1)) + PROD_W'(p3_t_ll_reg);
    assign p4_num_next = (PROD_W'(p3_n_hh_reg) << (2 * HALF_W))
                       + ((PROD_W'(p3_n_hl_reg) + PROD_W'(p3_n_lh_reg)) << HALF_W)
                       + PROD_W'(p3_n_ll_reg);

    // ---------------- stage 5: K^2 and quotient overflow check
    logic              p5_valid_reg;
    mode_t             p5_mode_reg;
    logic [AMT_W-1:0]  p5_other_reg;
    logic              p5_up_reg, p5_rej_reg, p5_ovf_reg;
    logic [PROD_W-1:0] p5_k2_reg, p5_sqt_reg, p5_num_reg;

    // ---------------- stage 6: radicand, inbound range check and divider operands
    logic              p6_valid_reg;
    mode_t             p6_mode_reg;
    logic [AMT_W-1:0]  p6_other_reg;
    logic              p6_up_reg, p6_rej_reg, p6_ovf_reg;
    logic [PROD_W-1:0] p6_x_reg;
    logic [AMT_W-1:0]  p6_nlo_reg, p6_drem_reg;
    logic              p6_rej_next;

    assign p6_rej_next = (p5_mode_reg == MODE_IN) ? (p5_sqt_reg > p5_k2_reg) : p5_rej_reg;

    // ---------------- iteration stages: one root bit each, one quotient bit in all but the last
    iter_t             it_in;
    iter_t             it_reg  [ROOT_W];
    iter_t             it_next [ROOT_W];
    logic [ROOT_W-1:0] it_valid_reg;

    always_comb
    begin
        it_in.mode  = p6_mode_reg;
        it_in.rej   = p6_rej_reg;
        it_in.ovf   = p6_ovf_reg;
        it_in.up    = p6_up_reg;
        it_in.other = p6_other_reg;
        it_in.x     = p6_x_reg;
        it_in.srem  = '0;
        it_in.root  = '0;
        it_in.nlo   = p6_nlo_reg;
        it_in.drem  = p6_drem_reg;
        it_in.quo   = '0;
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_iter
        iter_t src;

        if (j == 0)
        begin : g_first
            assign src = it_in;
        end
        else
        begin : g_rest
            assign src = it_reg[j-1];
        end

        always_comb
        begin
            logic [SREM_W-1:0] sh;
            logic [SREM_W-1:0] tr;
            logic [AMT_W:0]    dsh;
            logic [AMT_W:0]    dsub;
            it_next[j]   = src;
            sh           = {src.srem[ROOT_W-1:0], src.x[PROD_W-1 -: 2]};
            tr           = {src.root, 2'b01};
            it_next[j].x = src.x << 2;
            if (sh >= tr)
            begin
                it_next[j].srem = sh - tr;
                it_next[j].root = {src.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                it_next[j].srem = sh;
                it_next[j].root = {src.root[ROOT_W-2:0], 1'b0};
            end
            dsh  = {src.drem, src.nlo[AMT_W-1]};
            dsub = dsh - {1'b0, src.other};
            // the divider needs one step fewer than the root
            if (j < AMT_W)
            begin
                it_next[j].nlo = src.nlo << 1;
                if (dsh >= {1'b0, src.other})
                begin
                    it_next[j].drem = dsub[AMT_W-1:0];
                    it_next[j].quo  = {src.quo[AMT_W-2:0], 1'b1};
                end
                else
                begin
                    it_next[j].drem = dsh[AMT_W-1:0];
                    it_next[j].quo  = {src.quo[AMT_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- output stage
    iter_t             fin;
    logic [ROOT_W-1:0] fin_value;
    logic              fin_sat;
    logic [AMT_W-1:0]  fin_amount;
    logic              fin_rej;

    logic              out_valid_reg;
    logic [AMT_W-1:0]  out_amount_reg;
    logic              out_rej_reg, out_sat_reg;

    assign fin = it_reg[ROOT_W-1];

    always_comb
    begin
        fin_value = '0;
        fin_sat   = 1'b0;
        fin_rej   = 1'b0;
        case (fin.mode)
            MODE_OUT:
            begin
                fin_value = fin.root - {1'b0, fin.other};
                fin_rej   = fin.rej;
                fin_sat   = fin_value[ROOT_W-1];
            end
            MODE_IN:
            begin
                fin_value = {1'b0, fin.other} - fin.root;
                fin_rej   = fin.rej;
                fin_sat   = fin_value[ROOT_W-1];
            end
            MODE_RATE:
            begin
                fin_value = {1'b0, fin.quo} + {{AMT_W{1'b0}}, fin.up};
                fin_sat   = fin.ovf | fin_value[ROOT_W-1];
            end
            default:
            begin
                fin_value = '0;
            end
        endcase
        if (fin_rej)
        begin
            fin_sat    = 1'b0;
            fin_amount = '0;
        end
        else if (fin_sat)
            fin_amount = AMT_MAX;
        else
            fin_amount = fin_value[AMT_W-1:0];
    end

    // ---------------- handshake: every stage moves unless the output is held
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_amount_reg);
    assign m_tuser  = {out_sat_reg, out_rej_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            it_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= s_tvalid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            p6_valid_reg  <= p5_valid_reg;
            it_valid_reg  <= {it_valid_reg[ROOT_W-2:0], p6_valid_reg};
            out_valid_reg <= it_valid_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_mode_reg    <= in_mode;
            p1_this_reg    <= in_this;
            p1_other_reg   <= in_other;
            p1_d_reg       <= in_d;
            p1_up_reg      <= s_tuser[3];

            p2_mode_reg    <= p1_mode_reg;
            p2_this_reg    <= p1_this_reg;
            p2_other_reg   <= p1_other_reg;
            p2_d_reg       <= p1_d_reg;
            p2_up_reg      <= p1_up_reg;
            p2_t_reg       <= p2_t_next;
            p2_rej_reg     <= (p1_mode_reg == MODE_OUT) && (p1_d_reg > p1_this_reg);

            p3_mode_reg    <= p2_mode_reg;
            p3_other_reg   <= p2_other_reg;
            p3_up_reg      <= p2_up_reg;
            p3_rej_reg     <= p2_rej_reg;
            p3_a_hh_reg    <= w_this[ROOT_W-1:HALF_W] * w_this[ROOT_W-1:HALF_W];
            p3_a_hl_reg    <= w_this[ROOT_W-1:HALF_W] * w_this[HALF_W-1:0];
            p3_a_ll_reg    <= w_this[HALF_W-1:0] * w_this[HALF_W-1:0];
            p3_b_hh_reg    <= w_other[ROOT_W-1:HALF_W] * w_other[ROOT_W-1:HALF_W];
            p3_b_hl_reg    <= w_other[ROOT_W-1:HALF_W] * w_other[HALF_W-1:0];
            p3_b_ll_reg    <= w_other[HALF_W-1:0] * w_other[HALF_W-1:0];
            p3_t_hh_reg    <= p2_t_reg[ROOT_W-1:HALF_W] * p2_t_reg[ROOT_W-1:HALF_W];
            p3_t_hl_reg    <= p2_t_reg[ROOT_W-1:HALF_W] * p2_t_reg[HALF_W-1:0];
            p3_t_ll_reg    <= p2_t_reg[HALF_W-1:0] * p2_t_reg[HALF_W-1:0];
            p3_n_hh_reg    <= w_d[ROOT_W-1:HALF_W] * w_this[ROOT_W-1:HALF_W];
            p3_n_hl_reg    <= w_d[ROOT_W-1:HALF_W] * w_this[HALF_W-1:0];
            p3_n_lh_reg    <= w_this[ROOT_W-1:HALF_W] * w_d[HALF_W-1:0];
            p3_n_ll_reg    <= w_d[HALF_W-1:0] * w_this[HALF_W-1:0];

            p4_mode_reg    <= p3_mode_reg;
            p4_other_reg   <= p3_other_reg;
            p4_up_reg      <= p3_up_reg;
            p4_rej_reg     <= p3_rej_reg;
            p4_sqa_reg     <= p4_sqa_next;
            p4_sqb_reg     <= p4_sqb_next;
            p4_sqt_reg     <= p4_sqt_next;
            p4_num_reg     <= p4_num_next;

            p5_mode_reg    <= p4_mode_reg;
            p5_other_reg   <= p4_other_reg;
            p5_up_reg      <= p4_up_reg;
            p5_rej_reg     <= p4_rej_reg;
            p5_k2_reg      <= p4_sqa_reg + p4_sqb_reg;
            p5_sqt_reg     <= p4_sqt_reg;
            p5_num_reg     <= p4_num_reg;
            // quotient fits only if the product's bits above the low AMT_W are below the divisor
            p5_ovf_reg     <= p4_num_reg[PROD_W-1:AMT_W] >= (PROD_W-AMT_W)'(p4_other_reg);

            p6_mode_reg    <= p5_mode_reg;
            p6_other_reg   <= p5_other_reg;
            p6_up_reg      <= p5_up_reg;
            p6_rej_reg     <= p6_rej_next;
            p6_ovf_reg     <= p5_ovf_reg;
            p6_x_reg       <= p5_k2_reg - p5_sqt_reg;
            p6_nlo_reg     <= p5_num_reg[AMT_W-1:0];
            p6_drem_reg    <= p5_num_reg[2*AMT_W-1:AMT_W];

            it_reg         <= it_next;

            out_amount_reg <= fin_amount;
            out_rej_reg    <= fin_rej;
            out_sat_reg    <= fin_sat;
        end
    end

`ifndef SYNTH
    a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[AMT_W-1:0] == '0)
        else $error("rejected item with nonzero amount");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[AMT_W-1:0] == AMT_MAX)
        else $error("saturated item not clipped to maximum");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("item both rejected and saturated");

    a_last_feeds_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && it_valid_reg[ROOT_W-1] |=> out_valid_reg)
        else $error("item lost leaving the last iteration stage");
`endif

endmodule

`default_nettype wire
